// ===== design/clcd_pkg.sv =====
// Shared types and constants for the character LCD nibble write sequencer.
// No dependencies; every design file imports this package.
package clcd_pkg;

    // Operation codes on the input item
    localparam logic [1:0] OP_COMMAND  = 2'd0;
    localparam logic [1:0] OP_CHAR     = 2'd1;
    localparam logic [1:0] OP_POSITION = 2'd2;
    localparam logic [1:0] OP_INIT     = 2'd3;

    // Row codes for set position
    localparam logic [1:0] ROW_ONE = 2'd1;
    localparam logic [1:0] ROW_TWO = 2'd2;

    localparam logic [7:0] DDRAM_ROW1_BASE = 8'h80;
    localparam logic [7:0] DDRAM_ROW2_BASE = 8'hC0;

    // Config register indexes
    localparam logic [2:0] REG_SETUP     = 3'd0;
    localparam logic [2:0] REG_PULSE     = 3'd1;
    localparam logic [2:0] REG_CHAR      = 3'd2;
    localparam logic [2:0] REG_SETTLE    = 3'd3;
    localparam logic [2:0] REG_POST      = 3'd4;
    localparam logic [2:0] REG_POWER_UP  = 3'd5;

    // Config register reset values
    localparam logic [9:0]  SETUP_RESET    = 10'd1;
    localparam logic [16:0] PULSE_RESET    = 17'd1000;
    localparam logic [16:0] CHAR_RESET     = 17'd50;
    localparam logic [16:0] SETTLE_RESET   = 17'd2000;
    localparam logic [16:0] POST_RESET     = 17'd5000;
    localparam logic [19:0] POWER_UP_RESET = 20'd250000;

    localparam logic [2:0] LAST_PHASE    = 3'd4;
    localparam logic [2:0] LAST_INIT_CMD = 3'd4;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic [1:0] row;
        logic [5:0] column;
    } in_item_t;

    typedef struct packed {
        logic        reg_select;
        logic        enable;
        logic [3:0]  data_nibble;
        logic [19:0] hold_us;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [9:0]  setup_time_us;
        logic [16:0] enable_pulse_us;
        logic [16:0] char_phase_us;
        logic [16:0] command_settle_us;
        logic [16:0] post_wait_us;
        logic [19:0] power_up_wait_us;
    } cfg_t;

    typedef enum logic [1:0] {
        JOB_CMD,
        JOB_CHAR,
        JOB_WAIT,
        JOB_INIT
    } job_kind_t;

    typedef struct packed {
        job_kind_t  kind;
        logic [7:0] byte_code;
        logic       long_settle;
    } job_t;

    // Fixed power-up command list
    function automatic logic [7:0] init_command(input logic [2:0] idx);
        logic [7:0] code;
        case (idx)
            3'd0:    code = 8'h02;
            3'd1:    code = 8'h28;
            3'd2:    code = 8'h06;
            3'd3:    code = 8'h0C;
            default: code = 8'h01;
        endcase
        return code;
    endfunction

endpackage

// ===== design/clcd_front.sv =====
// Front end: classifies an input item into a bus job.
// Depends on clcd_pkg.
module clcd_front
    import clcd_pkg::*;
(
    input  in_item_t in_item,
    output job_t     job
);

    logic [7:0] col_byte;

    // DDRAM column offset, wraps modulo 256
    assign col_byte = {2'b00, in_item.column} - 8'd1;

    always_comb
    begin
        job.kind        = JOB_CMD;
        job.byte_code   = in_item.data_byte;
        job.long_settle = 1'b0;
        unique case (in_item.operation)
            OP_COMMAND:
            begin
                job.kind = JOB_CMD;
            end
            OP_CHAR:
            begin
                job.kind = JOB_CHAR;
            end
            OP_POSITION:
            begin
                job.long_settle = 1'b1;
                unique case (in_item.row)
                    ROW_ONE:
                    begin
                        job.kind      = JOB_CMD;
                        job.byte_code = DDRAM_ROW1_BASE + col_byte;
                    end
                    ROW_TWO:
                    begin
                        job.kind      = JOB_CMD;
                        job.byte_code = DDRAM_ROW2_BASE + col_byte;
                    end
                    default:
                    begin
                        job.kind = JOB_WAIT;
                    end
                endcase
            end
            default:
            begin
                job.kind        = JOB_INIT;
                job.long_settle = 1'b1;
            end
        endcase
    end

endmodule

// ===== design/clcd_queue.sv =====
// Two-entry job queue between front end and bus sequencer.
// Depends on clcd_pkg.
module clcd_queue
    import clcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic valid,
    input  logic pop,
    output job_t pop_job
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_job = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> valid)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue pushed while full");

endmodule

// ===== design/clcd_back.sv =====
// Bus sequencer: expands a job into timed pin states, one per cycle while out_stall is low.
// Depends on clcd_pkg.
module clcd_back
    import clcd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      job_valid,
    input  job_t      job,
    output logic      job_pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_item
);

    logic       busy_reg;
    job_t       job_reg;
    logic [2:0] phase_reg;
    logic [2:0] init_idx_reg;
    logic       init_wait_reg;
    logic [7:0] lat_byte_reg;
    logic       lat_char_reg;
    logic       out_valid_reg;
    out_item_t  out_reg;

    logic       advance;
    logic [7:0] cmd_byte;
    logic [19:0] settle;
    out_item_t  cur;
    logic       cmd_done;

    assign advance   = busy_reg && (!out_valid_reg || !out_stall);
    assign job_pop   = !busy_reg && job_valid;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assign cmd_byte = (job_reg.kind == JOB_INIT) ? init_command(init_idx_reg)
                                                 : job_reg.byte_code;
    assign settle   = job_reg.long_settle
                    ? {3'b000, cfg.command_settle_us} + {3'b000, cfg.post_wait_us}
                    : {3'b000, cfg.command_settle_us};

    // a command byte finishes on its settle state
    assign cmd_done = (phase_reg == LAST_PHASE)
                   && ((job_reg.kind == JOB_CMD)
                    || ((job_reg.kind == JOB_INIT) && !init_wait_reg));

    always_comb
    begin
        cur             = '0;
        cur.reg_select  = lat_char_reg;
        cur.data_nibble = lat_char_reg ? 4'h0 : lat_byte_reg[3:0];
        unique case (job_reg.kind) inside
            JOB_WAIT:
            begin
                cur.hold_us = {3'b000, cfg.post_wait_us};
                cur.last    = 1'b1;
            end
            JOB_CHAR:
            begin
                cur.reg_select  = 1'b1;
                cur.enable      = phase_reg[0];
                cur.data_nibble = 4'h0;
                cur.hold_us     = {3'b000, cfg.char_phase_us};
                case (phase_reg)
                    3'd1: cur.data_nibble = job_reg.byte_code[7:4];
                    3'd3: cur.data_nibble = job_reg.byte_code[3:0];
                    3'd4:
                    begin
                        cur.hold_us = '0;
                        cur.last    = 1'b1;
                    end
                    default: ;
                endcase
            end
            JOB_CMD, JOB_INIT:
            begin
                if ((job_reg.kind == JOB_INIT) && init_wait_reg)
                begin
                    cur.hold_us = cfg.power_up_wait_us;
                end
                else
                begin
                    cur.reg_select  = 1'b0;
                    cur.enable      = phase_reg[0];
                    cur.data_nibble = (phase_reg < 3'd2) ? cmd_byte[7:4] : cmd_byte[3:0];
                    case (phase_reg) inside
                        3'd0, 3'd2: cur.hold_us = {10'd0, cfg.setup_time_us};
                        3'd1, 3'd3: cur.hold_us = {3'b000, cfg.enable_pulse_us};
                        default:
                        begin
                            cur.hold_us = settle;
                            cur.last    = (job_reg.kind == JOB_CMD)
                                       || (init_idx_reg == LAST_INIT_CMD);
                        end
                    endcase
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
        end
        if (advance)
        begin
            out_reg <= cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            phase_reg     <= '0;
            init_idx_reg  <= '0;
            init_wait_reg <= 1'b0;
            lat_byte_reg  <= '0;
            lat_char_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            if (job_pop)
            begin
                busy_reg      <= 1'b1;
                phase_reg     <= '0;
                init_idx_reg  <= '0;
                init_wait_reg <= (job.kind == JOB_INIT);
            end
            else if (advance)
            begin
                if (cmd_done)
                begin
                    lat_byte_reg <= cmd_byte;
                    lat_char_reg <= 1'b0;
                end
                else if ((job_reg.kind == JOB_CHAR) && (phase_reg == LAST_PHASE))
                begin
                    lat_byte_reg <= job_reg.byte_code;
                    lat_char_reg <= 1'b1;
                end

                if (cur.last)
                begin
                    busy_reg <= 1'b0;
                end
                else if (init_wait_reg)
                begin
                    init_wait_reg <= 1'b0;
                end
                else if (phase_reg == LAST_PHASE)
                begin
                    phase_reg    <= '0;
                    init_idx_reg <= init_idx_reg + 1'b1;
                end
                else
                begin
                    phase_reg <= phase_reg + 1'b1;
                end
            end
        end
    end

    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (phase_reg <= LAST_PHASE) && (init_idx_reg <= LAST_INIT_CMD))
        else $error("phase or init index out of range");

    a_strobe_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_reg.enable && out_reg.last))
        else $error("run ended with enable high");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |=> busy_reg && !$past(busy_reg))
        else $error("job taken while sequencer busy");

endmodule

// ===== design/char_lcd_nibble_write_sequencer_core.sv =====
// Top level of the 4-bit character LCD write sequencer: config registers,
// front end, job queue and bus sequencer. Depends on clcd_pkg and submodules.
//
// Path: the first pin state of an item passes the queue, the sequencer job
// register and then the sequencer output register. One pin state per cycle
// while out_stall is low; no pin state comes out while the sequencer loads
// the next job between runs.
// Input stalls only when the two-entry job queue is full.
// Reset: config registers take their documented defaults, queue and sequencer
// empty, latched bus byte zero (command kind).
module char_lcd_nibble_write_sequencer_core
    import clcd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    // pin state channel
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    // APB config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t       cfg_reg;
    logic       cfg_write;
    logic [2:0] reg_idx;

    job_t front_job;
    job_t queue_job;
    logic queue_full;
    logic queue_valid;
    logic queue_pop;
    logic in_accept;

    // ------------------------------------------------------------------
    // Config registers: one per 32-bit word, low bits kept on write.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.setup_time_us     <= SETUP_RESET;
            cfg_reg.enable_pulse_us   <= PULSE_RESET;
            cfg_reg.char_phase_us     <= CHAR_RESET;
            cfg_reg.command_settle_us <= SETTLE_RESET;
            cfg_reg.post_wait_us      <= POST_RESET;
            cfg_reg.power_up_wait_us  <= POWER_UP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_SETUP:    cfg_reg.setup_time_us     <= pwdata[9:0];
                REG_PULSE:    cfg_reg.enable_pulse_us   <= pwdata[16:0];
                REG_CHAR:     cfg_reg.char_phase_us     <= pwdata[16:0];
                REG_SETTLE:   cfg_reg.command_settle_us <= pwdata[16:0];
                REG_POST:     cfg_reg.post_wait_us      <= pwdata[16:0];
                REG_POWER_UP: cfg_reg.power_up_wait_us  <= pwdata[19:0];
                default: ;  // addresses past the register list are ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_SETUP:    prdata = {22'd0, cfg_reg.setup_time_us};
            REG_PULSE:    prdata = {15'd0, cfg_reg.enable_pulse_us};
            REG_CHAR:     prdata = {15'd0, cfg_reg.char_phase_us};
            REG_SETTLE:   prdata = {15'd0, cfg_reg.command_settle_us};
            REG_POST:     prdata = {15'd0, cfg_reg.post_wait_us};
            REG_POWER_UP: prdata = {12'd0, cfg_reg.power_up_wait_us};
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Front end: classify each accepted item straight into the queue.
    // ------------------------------------------------------------------
    assign in_stall  = queue_full;
    assign in_accept = in_valid && !queue_full;

    clcd_front u_front (
        .in_item (in_item),
        .job     (front_job)
    );

    clcd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (in_accept),
        .push_job (front_job),
        .full     (queue_full),
        .valid    (queue_valid),
        .pop      (queue_pop),
        .pop_job  (queue_job)
    );

    // ------------------------------------------------------------------
    // Back end: walks each job through its pin states; owns the latched
    // bus byte used by wait-only states.
    // ------------------------------------------------------------------
    clcd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .job_valid (queue_valid),
        .job       (queue_job),
        .job_pop   (queue_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item)
    );

endmodule
